/* rtl/wtsc_pkg.sv */
// Shared types, codes and the sample function for the wave-table sound channel.
// Used by wtsc_regs, wtsc_ctrl, wtsc_dp and wave_table_sound_channel_top.
package wtsc_pkg;

	localparam int WAVE_SAMPLES = 32;
	localparam int POS_W        = $clog2(WAVE_SAMPLES);
	localparam int WAVE_BITS    = WAVE_SAMPLES * 4;
	localparam int FREQ_W       = 11;
	localparam int PERIOD_W     = 13;
	localparam int LEN_W        = 9;
	localparam int SAMPLE_W     = 7;
	localparam int DIV_STEPS    = PERIOD_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);
	localparam int PERIOD_BASE  = 2048;
	localparam int LEN_MAX      = 256;

	// input op codes
	localparam logic [1:0] OP_CYCLES  = 2'd0;
	localparam logic [1:0] OP_SEQ     = 2'd1;
	localparam logic [1:0] OP_TRIGGER = 2'd2;

	// register indexes
	localparam logic [2:0] REG_FREQ    = 3'd0;
	localparam logic [2:0] REG_LEVEL   = 3'd1;
	localparam logic [2:0] REG_LEN_EN  = 3'd2;
	localparam logic [2:0] REG_WAVE_LO = 3'd3;
	localparam logic [2:0] REG_WAVE_HI = 3'd4;

	// volume levels
	localparam logic [1:0] LVL_MUTE    = 2'd0;
	localparam logic [1:0] LVL_FULL    = 2'd1;
	localparam logic [1:0] LVL_HALF    = 2'd2;
	localparam logic [1:0] LVL_QUARTER = 2'd3;

	typedef struct packed {
		logic [FREQ_W-1:0]    freq;
		logic [1:0]           level;
		logic                 len_en;
		logic [WAVE_BITS-1:0] wave;
	} cfg_t;

	typedef struct packed {
		logic             load;     // word accepted this cycle
		logic             div_go;   // accepted word starts the period divide
		logic             div_step;
		logic [CNT_W-1:0] div_idx;
		logic             pos_upd;
		logic             samp_upd;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic rem_ok;   // timer below the period
	} sts_t;

	function automatic logic signed [SAMPLE_W-1:0] wave_sample(
		input logic [WAVE_BITS-1:0] wave,
		input logic [POS_W-1:0]     pos,
		input logic [1:0]           level
	);
		logic [7:0]                 byte_v;
		logic [3:0]                 nib;
		logic signed [SAMPLE_W-1:0] ctr;
		logic signed [SAMPLE_W-1:0] res;
		byte_v = wave[{pos[POS_W-1:1], 3'b000} +: 8];
		nib    = pos[0] ? byte_v[3:0] : byte_v[7:4];
		ctr    = $signed({3'b000, nib}) - 7'sd7;
		case (level)
			LVL_FULL:    res = ctr <<< 2;
			LVL_HALF:    res = ctr <<< 1;
			LVL_QUARTER: res = ctr;
			default:     res = '0;
		endcase
		return res;
	endfunction

endpackage

/* rtl/wtsc_regs.sv */
// APB-style configuration registers of the wave-table sound channel.
// Depends on wtsc_pkg for register indexes and the cfg_t bundle.
module wtsc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	output wtsc_pkg::cfg_t      cfg
);

	logic [wtsc_pkg::FREQ_W-1:0] freq_q;
	logic [1:0]                  level_q;
	logic                        len_en_q;
	logic [63:0]                 wave_lo_q;
	logic [63:0]                 wave_hi_q;
	logic [2:0]                  idx;
	logic                        wr;

	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q    <= '0;
			level_q   <= '0;
			len_en_q  <= 1'b0;
			wave_lo_q <= '0;
			wave_hi_q <= '0;
		end else if (wr) begin
			case (idx)
				wtsc_pkg::REG_FREQ:    freq_q    <= pwdata[wtsc_pkg::FREQ_W-1:0];
				wtsc_pkg::REG_LEVEL:   level_q   <= pwdata[1:0];
				wtsc_pkg::REG_LEN_EN:  len_en_q  <= pwdata[0];
				wtsc_pkg::REG_WAVE_LO: wave_lo_q <= pwdata;
				wtsc_pkg::REG_WAVE_HI: wave_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			wtsc_pkg::REG_FREQ:    prdata = {53'd0, freq_q};
			wtsc_pkg::REG_LEVEL:   prdata = {62'd0, level_q};
			wtsc_pkg::REG_LEN_EN:  prdata = {63'd0, len_en_q};
			wtsc_pkg::REG_WAVE_LO: prdata = wave_lo_q;
			wtsc_pkg::REG_WAVE_HI: prdata = wave_hi_q;
			default:               prdata = '0;
		endcase
	end

	assign cfg.freq   = freq_q;
	assign cfg.level  = level_q;
	assign cfg.len_en = len_en_q;
	assign cfg.wave   = {wave_hi_q, wave_lo_q};

endmodule

/* rtl/wtsc_ctrl.sv */
// Control state machine: sequences the period divide, position and sample
// updates and the output word. Depends on wtsc_pkg for cmd_t and sts_t.
module wtsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	output logic                out_valid,
	input  logic                out_ready,
	input  wtsc_pkg::sts_t      sts,
	output wtsc_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_POS  = 3'd2;
	localparam logic [2:0] ST_SAMP = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                 state_q;
	logic [wtsc_pkg::CNT_W-1:0] cnt_q;
	logic                       ov_q;
	logic                       acc;
	logic                       go_div;
	logic                       ld_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid & in_ready;
	assign go_div    = acc & (op == wtsc_pkg::OP_CYCLES) & sts.active;
	assign ld_out    = (state_q == ST_DONE) & (~ov_q | out_ready);
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= go_div ? ST_DIV : ST_DONE;
						cnt_q   <= wtsc_pkg::CNT_W'(wtsc_pkg::DIV_STEPS - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_POS;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_POS:  state_q <= ST_SAMP;
				ST_SAMP: state_q <= ST_DONE;
				ST_DONE: begin
					if (ld_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ld_out)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	assign cmd.load     = acc;
	assign cmd.div_go   = go_div;
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.div_idx  = cnt_q;
	assign cmd.pos_upd  = (state_q == ST_POS);
	assign cmd.samp_upd = (state_q == ST_SAMP);
	assign cmd.out_load = ld_out;

endmodule

/* rtl/wtsc_dp.sv */
// Datapath: period timer with shift-subtract divide, wave position, length
// counter, held sample and output register. Depends on wtsc_pkg.
module wtsc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wtsc_pkg::cfg_t                        cfg,
	input  wtsc_pkg::cmd_t                        cmd,
	input  logic [1:0]                            op,
	input  logic [4:0]                            elapsed_cycles,
	input  logic [2:0]                            sequencer_step,
	input  logic [wtsc_pkg::LEN_W-1:0]            length_value,
	output logic signed [wtsc_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  channel_on,
	output wtsc_pkg::sts_t                        sts
);

	localparam int SH_W = wtsc_pkg::PERIOD_W + wtsc_pkg::DIV_STEPS - 1;

	logic [wtsc_pkg::PERIOD_W-1:0]       timer_q;
	logic [wtsc_pkg::POS_W-1:0]          pos_q;
	logic [wtsc_pkg::POS_W-1:0]          quo_q;
	logic [wtsc_pkg::LEN_W-1:0]          len_q;
	logic                                active_q;
	logic signed [wtsc_pkg::SAMPLE_W-1:0] held_q;
	logic signed [wtsc_pkg::SAMPLE_W-1:0] sample_q;
	logic                                on_q;

	logic [wtsc_pkg::PERIOD_W-2:0]       diff;
	logic [wtsc_pkg::PERIOD_W-1:0]       period;
	logic [SH_W-1:0]                     dsh;
	logic                                ge;
	logic [wtsc_pkg::POS_W-1:0]          qbit;
	logic                                len_tick;

	assign diff   = (wtsc_pkg::PERIOD_W-1)'(wtsc_pkg::PERIOD_BASE)
		- {1'b0, cfg.freq};
	assign period = {diff, 1'b0};
	// one quotient bit per step, from the top bit down
	assign dsh    = SH_W'(period) << cmd.div_idx;
	assign ge     = SH_W'(timer_q) >= dsh;
	assign qbit   = (ge && (cmd.div_idx < wtsc_pkg::CNT_W'(wtsc_pkg::POS_W)))
		? (wtsc_pkg::POS_W'(1) << cmd.div_idx) : '0;
	assign len_tick = cmd.load & (op == wtsc_pkg::OP_SEQ) & ~sequencer_step[0] & cfg.len_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			pos_q    <= '0;
			quo_q    <= '0;
			len_q    <= '0;
			active_q <= 1'b0;
			held_q   <= '0;
		end else begin
			if (cmd.load) begin
				case (op)
					wtsc_pkg::OP_CYCLES: begin
						if (!active_q)
							held_q <= '0;
					end
					wtsc_pkg::OP_TRIGGER: begin
						len_q    <= (length_value > wtsc_pkg::LEN_W'(wtsc_pkg::LEN_MAX))
							? wtsc_pkg::LEN_W'(wtsc_pkg::LEN_MAX) : length_value;
						active_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (len_tick) begin
				if (len_q != '0)
					len_q <= len_q - 1'b1;
				if (len_q <= wtsc_pkg::LEN_W'(1))
					active_q <= 1'b0;
			end
			if (cmd.div_go) begin
				timer_q <= timer_q + wtsc_pkg::PERIOD_W'(elapsed_cycles);
				quo_q   <= '0;
			end
			if (cmd.div_step && ge) begin
				timer_q <= timer_q - dsh[wtsc_pkg::PERIOD_W-1:0];
				quo_q   <= quo_q | qbit;
			end
			if (cmd.pos_upd)
				pos_q <= pos_q + quo_q;
			if (cmd.samp_upd)
				held_q <= wtsc_pkg::wave_sample(cfg.wave, pos_q, cfg.level);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= held_q;
			on_q     <= active_q;
		end
	end

	assign sample     = sample_q;
	assign channel_on = on_q;
	assign sts.active = active_q;
	assign sts.rem_ok = timer_q < period;

endmodule

/* rtl/wave_table_sound_channel_top.sv */
// Wave-table sound channel: a 32-step, 4-bit wave voice with a length counter.
// Valid/ready input and output channels, one result word per input word.
// APB-style register port: frequency, level, length enable, wave memory.
// Input ops: elapsed cycles (advances the period timer and wave position),
// frame sequencer step (length countdown on even steps), trigger (loads
// length, enables the channel).
// An elapsed-cycle word on an enabled channel passes through the 13 steps of
// the shift-subtract period divide (one quotient bit per cycle), a position
// update, a sample update and the output load; all other words go straight
// to the output load. A new word is accepted in the cycle after the previous
// one is loaded into the output register, so the channel never works on two
// words at once.
// Reset clears all but the output register: timer, position, length, enable.
// When the receiver stalls the finished word waits in the output register;
// one more input word may be accepted and worked on, then it waits for the
// output register to free.
module wave_table_sound_channel_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [5:0]                           paddr,
	input  logic [63:0]                          pwdata,
	output logic [63:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           op,
	input  logic [4:0]                           elapsed_cycles,
	input  logic [2:0]                           sequencer_step,
	input  logic [wtsc_pkg::LEN_W-1:0]           length_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [wtsc_pkg::SAMPLE_W-1:0] sample,
	output logic                                 channel_on
);

	wtsc_pkg::cfg_t cfg;
	wtsc_pkg::cmd_t cmd;
	wtsc_pkg::sts_t sts;

	wtsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wtsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wtsc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.op             (op),
		.elapsed_cycles (elapsed_cycles),
		.sequencer_step (sequencer_step),
		.length_value   (length_value),
		.sample         (sample),
		.channel_on     (channel_on),
		.sts            (sts)
	);

	// a trigger always leaves the channel enabled
	a_trig_on: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == wtsc_pkg::OP_TRIGGER |=> sts.active)
		else $error("trigger did not enable channel");

	// divide leaves the timer below the period
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pos_upd |-> sts.rem_ok)
		else $error("timer not below period after divide");

	// one word in flight: no accept right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// delivered sample stays in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample >= -7'sd28) && (sample <= 7'sd32))
		else $error("sample out of range");

endmodule

/* sim/wave_table_sound_channel_top_test.sv */
// Testbench for wave_table_sound_channel_top: directed and random words against
// a cycle-free prediction of the channel. Needs rtl/wtsc_pkg.sv and the top RTL.
// Random stalls on both channels, register writes between phases over APB.
`timescale 1ns / 100ps

module wave_table_sound_channel_top_test;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         SETTLE    = 20;   // a margin over the worst-case latency of an elapsed-cycle word
	localparam int         PHASES    = 11;
	localparam int         PER_PHASE = 50;
	localparam int         LONG_HOLD = 300;

	typedef struct {
		logic [1:0]                 op;
		logic [4:0]                 cyc;
		logic [2:0]                 step;
		logic [wtsc_pkg::LEN_W-1:0] len;
	} chan_word_t;

	typedef struct {
		logic signed [wtsc_pkg::SAMPLE_W-1:0] smp;
		logic                                 on;
	} chan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [4:0] elapsed_cycles = '0;
	logic [2:0] sequencer_step = '0;
	logic [wtsc_pkg::LEN_W-1:0] length_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [wtsc_pkg::SAMPLE_W-1:0] sample;
	logic channel_on;

	wave_table_sound_channel_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.elapsed_cycles (elapsed_cycles),
		.sequencer_step (sequencer_step),
		.length_value   (length_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.channel_on     (channel_on)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	chan_word_t   pending_words[$];
	chan_result_t expected_results[$];
	int           mismatches = 0;
	int           phase_no = -1;
	logic         hold_out = 1'b0;
	int           send_gap = 0;
	int           recv_gap = 0;

	// register shadow
	logic [wtsc_pkg::FREQ_W-1:0] sh_freq = '0;
	logic [1:0]                  sh_level = wtsc_pkg::LVL_MUTE;
	logic                        sh_len_en = 1'b0;
	logic [63:0]                 sh_wave_lo = '0;
	logic [63:0]                 sh_wave_hi = '0;

	// channel state
	int                                   len_count = 0;
	logic                                 chan_active = 1'b0;
	int                                   tmr_count = 0;
	int                                   wave_pos = 0;
	logic signed [wtsc_pkg::SAMPLE_W-1:0] held_smp = '0;

	function automatic logic signed [wtsc_pkg::SAMPLE_W-1:0] scaled_sample();
		int          byte_idx;
		logic [63:0] half;
		logic [7:0]  b;
		int          nib;
		int          ctr;
		byte_idx = wave_pos / 2;
		half     = (byte_idx < 8) ? sh_wave_lo : sh_wave_hi;
		b        = half[(byte_idx % 8) * 8 +: 8];
		nib      = (wave_pos % 2 == 1) ? int'(b[3:0]) : int'(b[7:4]);
		ctr      = nib - 7;
		case (sh_level)
			wtsc_pkg::LVL_FULL:    return wtsc_pkg::SAMPLE_W'(ctr * 4);
			wtsc_pkg::LVL_HALF:    return wtsc_pkg::SAMPLE_W'(ctr * 2);
			wtsc_pkg::LVL_QUARTER: return wtsc_pkg::SAMPLE_W'(ctr);
			default:               return '0;
		endcase
	endfunction

	task automatic advance_channel(input chan_word_t w);
		int           period;
		int           wraps;
		chan_result_t r;
		case (w.op)
			wtsc_pkg::OP_CYCLES: begin
				if (!chan_active) begin
					held_smp = '0;
				end else begin
					period    = (wtsc_pkg::PERIOD_BASE - int'(sh_freq)) * 2;
					tmr_count = tmr_count + int'(w.cyc);
					wraps     = tmr_count / period;
					tmr_count = tmr_count - wraps * period;
					wave_pos  = (wave_pos + wraps) % wtsc_pkg::WAVE_SAMPLES;
					held_smp  = scaled_sample();
				end
			end
			wtsc_pkg::OP_SEQ: begin
				if (!w.step[0] && sh_len_en) begin
					if (len_count > 0)
						len_count--;
					if (len_count == 0)
						chan_active = 1'b0;
				end
			end
			wtsc_pkg::OP_TRIGGER: begin
				len_count   = (w.len > wtsc_pkg::LEN_MAX) ? wtsc_pkg::LEN_MAX : int'(w.len);
				chan_active = 1'b1;
			end
			default: ;
		endcase
		r.smp = held_smp;
		r.on  = chan_active;
		expected_results.push_back(r);
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// mostly back to back (always in phase 2), some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (phase_no == 2 || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender
	always @(posedge clk) begin : drive_in
		chan_word_t w;
		if (in_valid && !in_ready) begin
			// word still pending, hold it
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_words.size() > 0) begin
			w = pending_words.pop_front();
			in_valid       <= 1'b1;
			op             <= w.op;
			elapsed_cycles <= w.cyc;
			sequencer_step <= w.step;
			length_value   <= w.len;
			send_gap       <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_out) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
			recv_gap  <= pick_gap();
		end
	end

	// long output stall while the sender keeps offering, so the input backs up
	initial begin
		wait (phase_no == 3);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_out <= 1'b0;
	end

	always @(posedge clk) begin : watch
		chan_word_t   w;
		chan_result_t e;
		if (in_valid && in_ready) begin
			w.op   = op;
			w.cyc  = elapsed_cycles;
			w.step = sequencer_step;
			w.len  = length_value;
			advance_channel(w);
		end
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected word sample=%0d on=%0b",
					sample, channel_on));
			end else begin
				e = expected_results.pop_front();
				if (sample !== e.smp)
					flag_mismatch($sformatf("sample %0d, want %0d", sample, e.smp));
				if (channel_on !== e.on)
					flag_mismatch($sformatf("channel_on %0b, want %0b", channel_on, e.on));
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			wtsc_pkg::REG_FREQ:    sh_freq    = val[wtsc_pkg::FREQ_W-1:0];
			wtsc_pkg::REG_LEVEL:   sh_level   = val[1:0];
			wtsc_pkg::REG_LEN_EN:  sh_len_en  = val[0];
			wtsc_pkg::REG_WAVE_LO: sh_wave_lo = val;
			wtsc_pkg::REG_WAVE_HI: sh_wave_hi = val;
			default: ;
		endcase
	endtask

	task automatic push_word(input logic [1:0] o, input int cyc, input int step, input int len);
		chan_word_t w;
		w.op   = o;
		w.cyc  = 5'(cyc);
		w.step = 3'(step);
		w.len  = wtsc_pkg::LEN_W'(len);
		pending_words.push_back(w);
	endtask

	function automatic chan_word_t rand_word();
		chan_word_t w;
		int         r;
		r      = $urandom_range(0, 99);
		w.cyc  = 5'($urandom_range(0, 31));
		w.step = 3'($urandom_range(0, 7));
		w.len  = wtsc_pkg::LEN_W'($urandom_range(0, 511));
		if (r < 55) begin
			w.op = wtsc_pkg::OP_CYCLES;
		end else if (r < 77) begin
			w.op = wtsc_pkg::OP_SEQ;
		end else if (r < 95) begin
			w.op = wtsc_pkg::OP_TRIGGER;
			// short lengths so the countdown actually expires
			if ($urandom_range(0, 3) != 0)
				w.len = wtsc_pkg::LEN_W'($urandom_range(0, 12));
		end else begin
			w.op = OP_UNUSED;
		end
		return w;
	endfunction

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stim
		logic [wtsc_pkg::FREQ_W-1:0] f;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// fastest period, full level, known nibble ramp
		reg_write(wtsc_pkg::REG_WAVE_LO, 64'h0123456789ABCDEF);
		reg_write(wtsc_pkg::REG_WAVE_HI, 64'hFEDCBA9876543210);
		reg_write(wtsc_pkg::REG_FREQ, 64'h7FF);
		reg_write(wtsc_pkg::REG_LEVEL, 64'(wtsc_pkg::LVL_FULL));
		push_word(wtsc_pkg::OP_CYCLES, 31, 0, 0);     // disabled: sample stays 0
		push_word(wtsc_pkg::OP_TRIGGER, 0, 0, 511);   // length saturates at 256
		push_word(wtsc_pkg::OP_CYCLES, 0, 0, 0);
		push_word(wtsc_pkg::OP_CYCLES, 2, 0, 0);
		push_word(wtsc_pkg::OP_CYCLES, 31, 7, 0);
		push_word(wtsc_pkg::OP_CYCLES, 1, 0, 0);
		push_word(wtsc_pkg::OP_CYCLES, 1, 0, 0);
		push_word(OP_UNUSED, 31, 7, 511);
		push_word(wtsc_pkg::OP_SEQ, 0, 0, 0);         // length counting off
		wait_idle();

		reg_write(wtsc_pkg::REG_LEN_EN, 64'h1);
		reg_write(wtsc_pkg::REG_LEVEL, 64'(wtsc_pkg::LVL_QUARTER));
		push_word(wtsc_pkg::OP_TRIGGER, 0, 0, 2);
		push_word(wtsc_pkg::OP_SEQ, 0, 1, 0);         // odd step, no count
		push_word(wtsc_pkg::OP_SEQ, 0, 0, 0);
		push_word(wtsc_pkg::OP_SEQ, 0, 2, 0);         // reaches zero, channel off
		push_word(wtsc_pkg::OP_CYCLES, 5, 0, 0);
		push_word(wtsc_pkg::OP_TRIGGER, 0, 0, 0);
		push_word(wtsc_pkg::OP_CYCLES, 31, 0, 0);
		push_word(wtsc_pkg::OP_SEQ, 0, 6, 0);         // zero length disables at once
		wait_idle();

		// slowest period, then shorten it with the timer well above
		reg_write(wtsc_pkg::REG_FREQ, 64'h0);
		reg_write(wtsc_pkg::REG_LEVEL, 64'(wtsc_pkg::LVL_HALF));
		reg_write(wtsc_pkg::REG_LEN_EN, 64'h0);
		push_word(wtsc_pkg::OP_TRIGGER, 0, 0, 256);
		repeat (4) push_word(wtsc_pkg::OP_CYCLES, 31, 0, 0);
		wait_idle();
		reg_write(wtsc_pkg::REG_FREQ, 64'h7FF);
		push_word(wtsc_pkg::OP_CYCLES, 3, 0, 0);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: f = 11'h7FF;
				1: f = 11'h000;
				default:
					case ($urandom_range(0, 3))
						0: f = wtsc_pkg::FREQ_W'($urandom_range(0, 2047));
						1: f = 11'h7FF;
						default: f = wtsc_pkg::FREQ_W'($urandom_range(2016, 2047));
					endcase
			endcase
			reg_write(wtsc_pkg::REG_FREQ, 64'(f));
			reg_write(wtsc_pkg::REG_LEVEL, 64'((ph < 4) ? ph : $urandom_range(0, 3)));
			reg_write(wtsc_pkg::REG_LEN_EN, 64'((ph == 0) ? 1 : $urandom_range(0, 1)));
			reg_write(wtsc_pkg::REG_WAVE_LO, {$urandom, $urandom});
			reg_write(wtsc_pkg::REG_WAVE_HI, {$urandom, $urandom});
			phase_no = ph;
			for (int i = 0; i < PER_PHASE; i++)
				pending_words.push_back(rand_word());
			wait_idle();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
